FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl core of the click motion freeze filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

FILE: rtl/core/cmff_pkg.sv
// package: field widths, event codes and types of the click motion freeze filter
`default_nettype none

package cmff_pkg;

	localparam int TYPE_W     = 5;
	localparam int CODE_W     = 10;
	localparam int VALUE_W    = 32;
	localparam int TS_W       = 48;
	localparam int WAIT_W     = 32;
	localparam int THR_W      = 16;
	localparam int THR2_W     = 2 * THR_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// event types
	localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
	localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
	localparam logic [TYPE_W-1:0] EV_REL = 5'd2;

	// event codes
	localparam logic [CODE_W-1:0] BUTTON_L = 10'h110;
	localparam logic [CODE_W-1:0] BUTTON_R = 10'h111;
	localparam logic [CODE_W-1:0] BUTTON_M = 10'h112;
	localparam logic [CODE_W-1:0] REL_X    = 10'd0;
	localparam logic [CODE_W-1:0] REL_Y    = 10'd1;
	localparam logic [CODE_W-1:0] SYN_RPT  = 10'd0;

	// button values
	localparam logic signed [VALUE_W-1:0] BTN_RELEASE = 32'sd0;
	localparam logic signed [VALUE_W-1:0] BTN_PRESS   = 32'sd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIME   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESH = 1'd1;

	// one forwarded event, optionally followed by a syn report beat
	typedef struct packed {
		logic [TYPE_W-1:0]         ev_type;
		logic [CODE_W-1:0]         ev_code;
		logic signed [VALUE_W-1:0] ev_value;
		logic                      two_beats;
	} res_rec_t;

endpackage

`default_nettype wire

FILE: rtl/core/cmff_evt_if.sv
// input event channel
`default_nettype none

interface cmff_evt_if;
	import cmff_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         event_type;
	logic [CODE_W-1:0]         event_code;
	logic signed [VALUE_W-1:0] event_value;
	logic [TS_W-1:0]           timestamp_us;

	modport source (
		output valid, event_type, event_code, event_value, timestamp_us,
		input  ready
	);
	modport sink (
		input  valid, event_type, event_code, event_value, timestamp_us,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/cmff_res_if.sv
// result event channel
`default_nettype none

interface cmff_res_if;
	import cmff_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         out_type;
	logic [CODE_W-1:0]         out_code;
	logic signed [VALUE_W-1:0] out_value;
	logic                      last;

	modport source (
		output valid, out_type, out_code, out_value, last,
		input  ready
	);
	modport sink (
		input  valid, out_type, out_code, out_value, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/cmff_cfg_if.sv
// configuration register write channel
`default_nettype none

interface cmff_cfg_if;
	import cmff_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/cmff_out_stage.sv
// result register: sends a forwarded event and its trailing syn report as beats
`default_nettype none

module cmff_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cmff_pkg::res_rec_t rec,
	output logic              free,
	cmff_res_if.source        res
);
	import cmff_pkg::*;

	logic     out_valid_q;
	logic     phase_q;
	res_rec_t rec_q;
	logic     last_beat;
	logic     done;

	assign last_beat = phase_q || !rec_q.two_beats;
	assign done      = out_valid_q && res.ready && last_beat;
	assign free      = !out_valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			phase_q     <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b0;
		end else if (out_valid_q && res.ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	// second beat is always the syn report
	assign res.valid     = out_valid_q;
	assign res.out_type  = phase_q ? EV_SYN : rec_q.ev_type;
	assign res.out_code  = phase_q ? SYN_RPT : rec_q.ev_code;
	assign res.out_value = phase_q ? '0 : rec_q.ev_value;
	assign res.last      = last_beat;

endmodule

`default_nettype wire

FILE: rtl/core/click_motion_freeze_filter_core.sv
// top level of the click motion freeze filter
// A left, right or middle button press freezes relative X/Y motion: while frozen, motion
// beats are summed into saturating accumulators and dropped, until the squared distance
// exceeds the squared threshold or the wait window runs out, which unfreezes the filter and
// forwards that motion beat. A release unfreezes after a second press or once the wait has
// passed. Forwarded button and motion events and SYN events are followed by a SYN report,
// other events pass as one beat. An item enters the input register every cycle while
// that register is empty or advancing, and is settled once the stages after it can take
// it; the single result register sends one beat per cycle while res.ready is high. A
// motion beat while frozen passes through the squaring stage, during which the input
// register holds. A threshold write is squared into its register in the same cycle.
`default_nettype none
`include "assert_macros.svh"

module click_motion_freeze_filter_core #(
	parameter int ACCUM_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	cmff_evt_if.sink   evt,
	cmff_cfg_if.sink   cfg,
	cmff_res_if.source res
);
	import cmff_pkg::*;

	localparam int SW    = VALUE_W + 1;
	localparam int SQ_W  = 2 * ACCUM_BITS;
	localparam int CW    = (SQ_W + 1 > THR2_W) ? SQ_W + 1 : THR2_W;
	localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (ACCUM_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

	// configuration
	logic [WAIT_W-1:0] wait_q;
	logic [THR2_W-1:0] thr2_q;
	logic [THR_W-1:0]  thr_wr;

	// filter state
	logic [TS_W-1:0]              press_time_q;
	logic                         first_q;
	logic                         second_q;
	logic                         held_q;
	logic signed [ACCUM_BITS-1:0] x_acc_q;
	logic signed [ACCUM_BITS-1:0] y_acc_q;

	// input register
	logic                      valid_s1;
	logic [TYPE_W-1:0]         type_s1;
	logic [CODE_W-1:0]         code_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [TS_W-1:0]           ts_s1;

	// squaring stage
	logic                      valid_s2;
	logic [CODE_W-1:0]         code_s2;
	logic signed [VALUE_W-1:0] value_s2;
	logic                      tmo_s2;
	logic [SQ_W-1:0]           xsq_s2;
	logic [SQ_W-1:0]           ysq_s2;

	logic is_btn;
	logic is_mot;
	logic is_x;
	logic mot_hold;
	logic two_s1;

	logic [TS_W:0]   elapsed;
	logic            elapsed_neg;
	logic            exceeded;
	logic            tmo;

	logic signed [ACCUM_BITS-1:0] acc_sel;
	logic signed [SW-1:0]         acc_sum;
	logic signed [ACCUM_BITS-1:0] acc_new;
	logic signed [ACCUM_BITS-1:0] x_next;
	logic signed [ACCUM_BITS-1:0] y_next;
	logic [ACCUM_BITS-1:0]        x_mag;
	logic [ACCUM_BITS-1:0]        y_mag;
	logic [CW-1:0]                dist2;

	logic     s2_end;
	logic     s2_retire;
	logic     s1_adv;
	logic     out_free;
	logic     out_load;
	res_rec_t out_rec;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;
	assign thr_wr    = cfg.data[THR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			thr2_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WAIT_TIME: begin
					wait_q <= cfg.data[WAIT_W-1:0];
				end
				REG_MOVE_THRESH: begin
					thr2_q <= thr_wr * thr_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- classification ----------------
	assign is_btn   = (type_s1 == EV_KEY) && (code_s1 inside {[BUTTON_L:BUTTON_M]});
	assign is_x     = (code_s1 == REL_X);
	assign is_mot   = (type_s1 == EV_REL) && (is_x || code_s1 == REL_Y);
	assign mot_hold = is_mot && held_q;
	assign two_s1   = is_btn || is_mot || (type_s1 == EV_SYN);

	// signed elapsed time since the first press
	assign elapsed     = {1'b0, ts_s1} - {1'b0, press_time_q};
	assign elapsed_neg = elapsed[TS_W];
	assign exceeded    = !elapsed_neg && (elapsed[TS_W-1:0] > TS_W'(wait_q));
	assign tmo         = !elapsed_neg && (elapsed[TS_W-1:0] >= TS_W'(wait_q));

	// ---------------- accumulate and square ----------------
	assign acc_sel = is_x ? x_acc_q : y_acc_q;
	assign acc_sum = SW'(acc_sel) + SW'(value_s1);

	always_comb begin
		if (acc_sum > ACC_MAX) begin
			acc_new = ACC_MAX[ACCUM_BITS-1:0];
		end else if (acc_sum < ACC_MIN) begin
			acc_new = ACC_MIN[ACCUM_BITS-1:0];
		end else begin
			acc_new = acc_sum[ACCUM_BITS-1:0];
		end
	end

	assign x_next = is_x ? acc_new : x_acc_q;
	assign y_next = is_x ? y_acc_q : acc_new;
	assign x_mag  = x_next[ACCUM_BITS-1] ? (~x_next[ACCUM_BITS-1:0] + 1'b1)
	                                     : x_next[ACCUM_BITS-1:0];
	assign y_mag  = y_next[ACCUM_BITS-1] ? (~y_next[ACCUM_BITS-1:0] + 1'b1)
	                                     : y_next[ACCUM_BITS-1:0];

	// ---------------- distance check ----------------
	assign dist2     = CW'(xsq_s2) + CW'(ysq_s2);
	assign s2_end    = tmo_s2 || (dist2 > CW'(thr2_q));
	assign s2_retire = valid_s2 && (!s2_end || out_free);

	// ---------------- flow control ----------------
	assign s1_adv    = valid_s1 && !valid_s2 && (mot_hold || out_free);
	assign evt.ready = !valid_s1 || s1_adv;
	assign out_load  = (s2_retire && s2_end) || (s1_adv && !mot_hold);

	always_comb begin
		if (valid_s2) begin
			out_rec = '{ev_type: EV_REL, ev_code: code_s2, ev_value: value_s2, two_beats: 1'b1};
		end else begin
			out_rec = '{ev_type: type_s1, ev_code: code_s1, ev_value: value_s1,
			            two_beats: two_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (evt.valid && evt.ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && mot_hold) begin
				valid_s2 <= 1'b1;
			end else if (s2_retire) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			type_s1  <= evt.event_type;
			code_s1  <= evt.event_code;
			value_s1 <= evt.event_value;
			ts_s1    <= evt.timestamp_us;
		end
		if (s1_adv && mot_hold) begin
			code_s2  <= code_s1;
			value_s2 <= value_s1;
			tmo_s2   <= tmo;
			xsq_s2   <= x_mag * x_mag;
			ysq_s2   <= y_mag * y_mag;
		end
	end

	// ---------------- filter state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_time_q <= '0;
			first_q      <= 1'b0;
			second_q     <= 1'b0;
			held_q       <= 1'b0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
		end else if (s2_retire && s2_end) begin
			press_time_q <= '0;
			first_q      <= 1'b0;
			second_q     <= 1'b0;
			held_q       <= 1'b0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
		end else if (s1_adv) begin
			if (is_btn) begin
				if (value_s1 == BTN_PRESS) begin
					if (!first_q) begin
						held_q       <= 1'b1;
						first_q      <= 1'b1;
						press_time_q <= ts_s1;
					end else begin
						second_q <= 1'b1;
					end
				end else if (value_s1 == BTN_RELEASE && (exceeded || second_q)) begin
					press_time_q <= '0;
					first_q      <= 1'b0;
					second_q     <= 1'b0;
					held_q       <= 1'b0;
					x_acc_q      <= '0;
					y_acc_q      <= '0;
				end
			end else if (mot_hold) begin
				x_acc_q <= x_next;
				y_acc_q <= y_next;
			end
		end
	end

	cmff_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.rec    (out_rec),
		.free   (out_free),
		.res    (res)
	);

	// ---------------- assertions ----------------
	`ASSERT_CLK(a_s2_only_frozen, valid_s2 |-> held_q, "squaring stage busy while not frozen")
	`ASSERT_CLK(a_second_after_first, second_q |-> first_q, "second press without first press")
	`ASSERT_CLK(a_acc_idle_zero, !held_q |-> (x_acc_q == '0 && y_acc_q == '0),
		"accumulators nonzero while not frozen")
	`ASSERT_NEVER(a_load_busy, out_load && !out_free, "result register loaded while busy")

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the click motion freeze filter: predicted event beats checked against the core
`timescale 1ns / 100ps

module tb;
	import cmff_pkg::*;

	localparam int ACC_BITS      = 24;
	localparam int STALL_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT   = 3000;

	typedef struct {
		logic [TYPE_W-1:0]         ev_type;
		logic [CODE_W-1:0]         ev_code;
		logic signed [VALUE_W-1:0] ev_value;
		logic [TS_W-1:0]           ts;
	} mouse_event_t;

	typedef struct packed {
		logic [TYPE_W-1:0]         ev_type;
		logic [CODE_W-1:0]         ev_code;
		logic signed [VALUE_W-1:0] ev_value;
		logic                      last;
	} out_beat_t;

	logic clk;
	logic arst_n;

	cmff_evt_if evt ();
	cmff_cfg_if cfg ();
	cmff_res_if res ();

	click_motion_freeze_filter_core #(
		.ACCUM_BITS(ACC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.cfg(cfg),
		.res(res)
	);

	// filter state as predicted
	logic [TS_W-1:0]   press_stamp;
	bit                press_one;
	bit                press_two;
	bit                frozen;
	longint            x_sum;
	longint            y_sum;
	logic [WAIT_W-1:0] wait_window;
	logic [THR_W-1:0]  move_limit;

	out_beat_t expected_beats[$];

	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          stall_request;
	logic [TS_W-1:0] stamp_us;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void unfreeze();
		press_stamp = '0;
		press_one   = 1'b0;
		press_two   = 1'b0;
		frozen      = 1'b0;
		x_sum       = 0;
		y_sum       = 0;
	endfunction

	function automatic longint clamp_sum(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic void queue_beat(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
			logic signed [VALUE_W-1:0] v, logic l);
		out_beat_t b;
		b.ev_type  = t;
		b.ev_code  = c;
		b.ev_value = v;
		b.last     = l;
		expected_beats.push_back(b);
	endfunction

	function automatic void filter_predict(mouse_event_t e);
		longint            elapsed;
		longint            dval;
		longint            win;
		longint unsigned   ax;
		longint unsigned   ay;
		longint unsigned   dist2;
		longint unsigned   thr2;
		elapsed = longint'({16'd0, e.ts}) - longint'({16'd0, press_stamp});
		dval    = longint'(e.ev_value);
		win     = longint'({32'd0, wait_window});
		if (e.ev_type == EV_KEY && e.ev_code >= BUTTON_L && e.ev_code <= BUTTON_M) begin
			if (e.ev_value == BTN_PRESS) begin
				if (!press_one) begin
					frozen      = 1'b1;
					press_one   = 1'b1;
					press_stamp = e.ts;
				end else begin
					press_two = 1'b1;
				end
			end else if (e.ev_value == BTN_RELEASE) begin
				if (elapsed > win || press_two)
					unfreeze();
			end
			queue_beat(e.ev_type, e.ev_code, e.ev_value, 1'b0);
			queue_beat(EV_SYN, SYN_RPT, '0, 1'b1);
		end else if (e.ev_type == EV_REL && (e.ev_code == REL_X || e.ev_code == REL_Y)) begin
			if (frozen) begin
				if (e.ev_code == REL_X)
					x_sum = clamp_sum(x_sum + dval);
				else
					y_sum = clamp_sum(y_sum + dval);
				ax    = longint'(x_sum < 0 ? -x_sum : x_sum);
				ay    = longint'(y_sum < 0 ? -y_sum : y_sum);
				dist2 = ax * ax + ay * ay;
				thr2  = longint'(move_limit) * longint'(move_limit);
				// swallowed while still inside both the distance and the time window
				if (dist2 > thr2 || !(elapsed < win))
					unfreeze();
				else
					return;
			end
			queue_beat(e.ev_type, e.ev_code, e.ev_value, 1'b0);
			queue_beat(EV_SYN, SYN_RPT, '0, 1'b1);
		end else begin
			queue_beat(e.ev_type, e.ev_code, e.ev_value, e.ev_type != EV_SYN);
			if (e.ev_type == EV_SYN)
				queue_beat(EV_SYN, SYN_RPT, '0, 1'b1);
		end
	endfunction

	function automatic mouse_event_t mk(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
			logic signed [VALUE_W-1:0] v, logic [TS_W-1:0] ts);
		mouse_event_t e;
		e.ev_type  = t;
		e.ev_code  = c;
		e.ev_value = v;
		e.ts       = ts;
		return e;
	endfunction

	// mostly well-formed click and motion traffic, some noise and odd timestamps
	function automatic mouse_event_t random_event();
		mouse_event_t e;
		int           r;
		r = $urandom_range(99);
		if (r < 90)
			stamp_us = stamp_us + 48'($urandom_range(400));
		else if (r < 98)
			stamp_us = stamp_us - 48'($urandom_range(2000));
		else
			stamp_us = TS_W'({$urandom, $urandom});
		e.ts = stamp_us;
		r = $urandom_range(99);
		if (r < 35) begin
			e.ev_type = EV_REL;
			e.ev_code = $urandom_range(1) ? REL_X : REL_Y;
			if ($urandom_range(9) == 0)
				e.ev_value = $urandom;
			else
				e.ev_value = $signed($urandom_range(60)) - 30;
		end else if (r < 55) begin
			e.ev_type = EV_KEY;
			e.ev_code = BUTTON_L + CODE_W'($urandom_range(2));
			if ($urandom_range(9) == 0)
				e.ev_value = $urandom_range(1) ? 32'sd2 : $signed($urandom);
			else
				e.ev_value = $urandom_range(1) ? BTN_PRESS : BTN_RELEASE;
		end else if (r < 75) begin
			e.ev_type  = EV_SYN;
			e.ev_code  = SYN_RPT;
			e.ev_value = '0;
		end else if (r < 82) begin
			// near misses of the button and motion classes
			e.ev_type  = $urandom_range(1) ? EV_KEY : EV_REL;
			e.ev_code  = (e.ev_type == EV_KEY) ? 10'h10F + CODE_W'($urandom_range(1) * 4)
				: CODE_W'($urandom_range(767, 2));
			e.ev_value = $urandom_range(1) ? BTN_PRESS : $signed($urandom);
		end else begin
			e.ev_type  = TYPE_W'($urandom_range(31));
			e.ev_code  = CODE_W'($urandom_range(767));
			e.ev_value = $urandom;
		end
		return e;
	endfunction

	task automatic send_event(input mouse_event_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			evt.valid <= 1'b0;
			@(negedge clk);
		end
		evt.valid        <= 1'b1;
		evt.event_type   <= e.ev_type;
		evt.event_code   <= e.ev_code;
		evt.event_value  <= e.ev_value;
		evt.timestamp_us <= e.ts;
		do @(posedge clk); while (!evt.ready);
		filter_predict(e);
		@(negedge clk);
	endtask

	// let the core run dry before touching its registers
	task automatic settle();
		evt.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input logic [WAIT_W-1:0] wait_us, input logic [THR_W-1:0] thr);
		settle();
		cfg.valid <= 1'b1;
		cfg.index <= REG_WAIT_TIME;
		cfg.data  <= wait_us;
		do @(posedge clk); while (!cfg.ready);
		wait_window = wait_us;
		@(negedge clk);
		cfg.index <= REG_MOVE_THRESH;
		cfg.data  <= {{(CFG_DATA_W - THR_W){1'b0}}, thr};
		do @(posedge clk); while (!cfg.ready);
		move_limit = thr;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic test_directed();
		set_config(32'd1000, 16'd10);
		send_event(mk(EV_SYN, SYN_RPT, '0, 48'd10));
		send_event(mk(5'd31, 10'd767, 32'sh8000_0000, 48'd20));
		send_event(mk(EV_SYN, 10'd767, 32'sh7FFF_FFFF, 48'd30));
		send_event(mk(EV_KEY, 10'h10F, BTN_PRESS, 48'd40));
		send_event(mk(5'd3, BUTTON_L, BTN_PRESS, 48'd50));
		send_event(mk(EV_REL, 10'd2, 32'sd5, 48'd60));
		// press freezes, small motion is swallowed, a second press is noted and autorepeat passes through
		send_event(mk(EV_KEY, BUTTON_L, BTN_PRESS, 48'd100));
		send_event(mk(EV_REL, REL_X, 32'sd3, 48'd150));
		send_event(mk(EV_REL, REL_Y, -32'sd4, 48'd160));
		send_event(mk(EV_KEY, BUTTON_R, BTN_PRESS, 48'd170));
		send_event(mk(EV_KEY, BUTTON_M, 32'sd2, 48'd180));
		send_event(mk(EV_REL, REL_X, 32'sd8, 48'd190));
		// early release keeps the freeze, time going backwards stays in the window
		send_event(mk(EV_KEY, BUTTON_L, BTN_PRESS, 48'd1000));
		send_event(mk(EV_KEY, BUTTON_L, BTN_RELEASE, 48'd1200));
		send_event(mk(EV_REL, REL_Y, 32'sd2, 48'd500));
		send_event(mk(EV_REL, REL_Y, 32'sh8000_0000, 48'd600));
		// late release
		send_event(mk(EV_KEY, BUTTON_R, BTN_PRESS, 48'd2000));
		send_event(mk(EV_KEY, BUTTON_R, BTN_RELEASE, 48'd3001));
		// motion exactly at the end of the window
		send_event(mk(EV_KEY, BUTTON_M, BTN_PRESS, 48'd4000));
		send_event(mk(EV_REL, REL_X, 32'sd1, 48'd5000));
		// release after a second press
		send_event(mk(EV_KEY, BUTTON_L, BTN_PRESS, 48'd6000));
		send_event(mk(EV_KEY, BUTTON_M, BTN_PRESS, 48'd6010));
		send_event(mk(EV_KEY, BUTTON_L, BTN_RELEASE, 48'd6020));
		// largest timestamp, saturating positive delta
		send_event(mk(EV_KEY, BUTTON_L, BTN_PRESS, 48'hFFFF_FFFF_FFFF));
		send_event(mk(EV_REL, REL_X, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF));
	endtask

	task automatic test_random_traffic(input logic [WAIT_W-1:0] wait_us,
			input logic [THR_W-1:0] thr, input int count);
		set_config(wait_us, thr);
		repeat (count) send_event(random_event());
	endtask

	task automatic test_output_stall();
		settle();
		stall_request = 1'b1;
		repeat (40) send_event(random_event());
	endtask

	task automatic test_extreme_settings();
		test_random_traffic(32'hFFFF_FFFF, 16'hFFFF, 40);
		test_random_traffic(32'd0, 16'd0, 40);
	endtask

	// result side: random ready, with one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		res.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				stall_left    = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t want;
		if (arst_n && res.valid && res.ready) begin
			got.ev_type  = res.out_type;
			got.ev_code  = res.out_code;
			got.ev_value = res.out_value;
			got.last     = res.last;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: type %0d code %0h value %0d last %0b",
						got.ev_type, got.ev_code, got.ev_value, got.last);
			end else begin
				want = expected_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp type %0d code %0h value %0d last %0b, %s",
							want.ev_type, want.ev_code, want.ev_value, want.last,
							$sformatf("got type %0d code %0h value %0d last %0b",
								got.ev_type, got.ev_code, got.ev_value, got.last));
				end
			end
		end
	end

	// watchdog on cycles without any beat accepted
	always @(posedge clk) begin
		int quiet;
		if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		evt.valid        = 1'b0;
		evt.event_type   = '0;
		evt.event_code   = '0;
		evt.event_value  = '0;
		evt.timestamp_us = '0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_WAIT_TIME;
		cfg.data         = '0;
		mismatches       = 0;
		stall_request    = 1'b0;
		stamp_us         = '0;
		wait_window      = '0;
		move_limit       = '0;
		unfreeze();
		send_idle_pct = 14;
		recv_idle_pct = 47;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic(32'd2500, 16'd24, 200);
		send_idle_pct = 47;
		recv_idle_pct = 14;
		test_random_traffic(32'd600, 16'd6, 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(32'd5000, 16'd40, 180);
		test_output_stall();
		test_extreme_settings();

		evt.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/cmff_pkg.sv
rtl/core/cmff_evt_if.sv
rtl/core/cmff_res_if.sv
rtl/core/cmff_cfg_if.sv
rtl/core/cmff_out_stage.sv
rtl/core/click_motion_freeze_filter_core.sv
sim/tb.sv
